FILE: sv/pis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_pkg: shared types and constants for pose inlier scoring
// Field widths, fixed-point constants and the controller/datapath command set.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int unsigned RegW   = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW   = 13;
  localparam int unsigned CostW  = 28;
  localparam int unsigned PcW    = 32;   // camera point, Q.12 over the point's scale, floored
  localparam int unsigned SqW    = 70;   // sum of squares
  localparam int unsigned NormW  = 35;
  localparam int unsigned DotW   = 52;
  localparam int unsigned QW     = 15;   // quotient bits kept (cap 16384)

  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  localparam logic [CfgIdxW-1:0] RegRot0  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRot1  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRot2  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTrans = 2'd3;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] bearing_x;
    logic signed [15:0] bearing_y;
    logic signed [15:0] bearing_z;
    logic signed [15:0] cos_threshold;
    logic               last_match;
  } match_t;

  typedef struct packed {
    logic               inlier_flag;
    logic signed [15:0] match_cosine;
    logic [CntW-1:0]    inlier_total;
    logic [CostW-1:0]   cost_total;
    logic               run_end;
  } score_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture the match
    logic [1:0] row;       // transform row to compute
    logic       row_en;
    logic       sums_en;   // form dot and sum of squares
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       finish;    // update totals and result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic zero_len;
  } dp_stat_t;

endpackage

FILE: sv/pis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_match_if / pis_score_if: valid/ready channels
// Carry one match word in and one score word out.
// ----------------------------------------------------------------------------
interface pis_match_if;
  logic              valid;
  logic              ready;
  pis_pkg::match_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pis_score_if;
  logic              valid;
  logic              ready;
  pis_pkg::score_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pose_inlier_scoring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_inlier_scoring: angular-error inlier test for one pose hypothesis
// Scores each match and keeps running inlier count and cost.
// ----------------------------------------------------------------------------
// One match at a time: after the match is accepted it passes three transform
// rows, one sum step, 35 square-root steps, 15 divide steps and one finish
// step; the bit-pair square root takes most of them. A zero-length point
// skips the divider. The next match is accepted as soon as the sequencer is
// idle, even while the previous word waits; if that word is still not taken
// when the next one is finished, the finish cycle stalls until it goes.
module pose_inlier_scoring #(
  parameter int unsigned MAX_MATCHES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pis_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [pis_pkg::RegW-1:0]    cfg_data,
  pis_match_if.sink                   match_in,
  pis_score_if.source                 score_out
);

  localparam int unsigned CountCap = (MAX_MATCHES < 8191) ? MAX_MATCHES : 8191;

  pis_pkg::dp_cmd_t  cmd;
  pis_pkg::dp_stat_t stat;

  pis_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (match_in.valid),
    .in_ready (match_in.ready),
    .out_valid(score_out.valid),
    .out_ready(score_out.ready),
    .stat, .cmd
  );

  pis_datapath #(.CountCap(CountCap)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .match_in(match_in.data),
    .cmd, .stat,
    .score(score_out.data)
  );

endmodule

FILE: sv/pis_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_datapath: transform, norm, divide and accumulate
// One transform row per step, bit-pair square root, restoring divider.
// ----------------------------------------------------------------------------
module pis_datapath #(
  parameter int unsigned CountCap = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pis_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [pis_pkg::RegW-1:0]   cfg_data,
  input  pis_pkg::match_t            match_in,
  input  pis_pkg::dp_cmd_t           cmd,
  output pis_pkg::dp_stat_t          stat,
  output pis_pkg::score_t            score
);

  logic [pis_pkg::RegW-1:0] rot0, rot1, rot2, trans;
  pis_pkg::match_t          m;
  logic signed [pis_pkg::PcW-1:0] pc [3];
  logic signed [pis_pkg::DotW-1:0] dot;
  logic [pis_pkg::SqW-1:0]  rem;
  logic [pis_pkg::NormW-1:0] root;
  logic [5:0]               sq_i;
  logic [pis_pkg::DotW-1:0] drem;
  logic [pis_pkg::QW-1:0]   quo;
  logic                     qbig;
  logic [3:0]               dv_i;
  logic [pis_pkg::CntW-1:0] cnt;
  logic [pis_pkg::CostW-1:0] cost;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot0  <= 48'd16384;
      rot1  <= 48'd16384 << 16;
      rot2  <= 48'd16384 << 32;
      trans <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pis_pkg::RegRot0:  rot0  <= cfg_data;
        pis_pkg::RegRot1:  rot1  <= cfg_data;
        pis_pkg::RegRot2:  rot2  <= cfg_data;
        pis_pkg::RegTrans: trans <= cfg_data;
        default: ;
      endcase
    end
  end

  // one transform row
  logic [pis_pkg::RegW-1:0] row_sel;
  logic signed [15:0]       t_sel;
  logic signed [40:0]       row_acc;
  always_comb begin
    unique case (cmd.row)
      2'd0:    begin row_sel = rot0; t_sel = trans[15:0];  end
      2'd1:    begin row_sel = rot1; t_sel = trans[31:16]; end
      default: begin row_sel = rot2; t_sel = trans[47:32]; end
    endcase
    row_acc = 41'(t_sel) * 41'sd16384
            + 41'($signed(row_sel[15:0]))  * 41'(m.point_x)
            + 41'($signed(row_sel[31:16])) * 41'(m.point_y)
            + 41'($signed(row_sel[47:32])) * 41'(m.point_z);
  end

  // sums of products of the camera point
  logic signed [pis_pkg::DotW-1:0]    dot_c;
  logic signed [2*pis_pkg::PcW-1:0]   pp0, pp1, pp2;
  logic [pis_pkg::SqW-1:0]            sq_c;
  always_comb begin
    dot_c = pis_pkg::DotW'(pc[0]) * pis_pkg::DotW'(m.bearing_x)
          + pis_pkg::DotW'(pc[1]) * pis_pkg::DotW'(m.bearing_y)
          + pis_pkg::DotW'(pc[2]) * pis_pkg::DotW'(m.bearing_z);
    pp0   = pc[0] * pc[0];
    pp1   = pc[1] * pc[1];
    pp2   = pc[2] * pc[2];
    sq_c  = pis_pkg::SqW'(pp0) + pis_pkg::SqW'(pp1) + pis_pkg::SqW'(pp2);
  end

  logic [pis_pkg::SqW-1:0]  sq_val;

  // divider step: quotient bit per cycle
  logic [pis_pkg::DotW:0] dsub;
  logic [pis_pkg::DotW-1:0] dshift;
  always_comb begin
    dshift = pis_pkg::DotW'(root) << dv_i;
    dsub   = {1'b0, drem} - {1'b0, dshift};
  end

  // finishing logic
  logic signed [15:0] cosv, thr, addv;
  logic               inl;
  logic [pis_pkg::CostW:0] csum;
  always_comb begin
    cosv = (qbig || quo > pis_pkg::QW'(16384)) ? pis_pkg::OneQ14 : $signed({1'b0, quo});
    if (dot[pis_pkg::DotW-1]) cosv = -cosv;
    if (stat.zero_len) cosv = '0;
    thr = m.cos_threshold;
    if (thr > pis_pkg::OneQ14)  thr = pis_pkg::OneQ14;
    if (thr < -pis_pkg::OneQ14) thr = -pis_pkg::OneQ14;
    inl  = !stat.zero_len && (thr < cosv);
    addv = inl ? pis_pkg::OneQ14 - cosv : pis_pkg::OneQ14 - thr;
    csum = {1'b0, cost} + (pis_pkg::CostW+1)'(unsigned'(addv));
  end

  assign stat.zero_len = (sq_val == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      cost <= '0;
    end else if (cmd.finish) begin
      if (m.last_match) begin
        cnt  <= '0;
        cost <= '0;
      end else begin
        if (inl && cnt < pis_pkg::CntW'(CountCap)) cnt <= cnt + 1'b1;
        cost <= csum[pis_pkg::CostW] ? '1 : csum[pis_pkg::CostW-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) m <= match_in;
    if (cmd.row_en) pc[cmd.row] <= pis_pkg::PcW'(row_acc >>> 2);
    if (cmd.sums_en) begin
      dot    <= dot_c;
      sq_val <= sq_c;
    end
    if (cmd.sqrt_init) begin
      rem  <= sq_c;
      root <= '0;
      sq_i <= 6'd34;
    end else if (cmd.sqrt_step) begin
      // remainder against (4*root+1) at the current bit pair
      if ((rem >> (2*sq_i)) >= pis_pkg::SqW'({root, 2'b01})) begin
        rem  <= rem - (pis_pkg::SqW'({root, 2'b01}) << (2*sq_i));
        root <= {root[pis_pkg::NormW-2:0], 1'b1};
      end else begin
        root <= {root[pis_pkg::NormW-2:0], 1'b0};
      end
      sq_i <= sq_i - 1'b1;
    end
    if (cmd.div_init) begin
      drem <= dot[pis_pkg::DotW-1] ? -dot : dot;
      dv_i <= 4'd14;
      quo  <= '0;
      // quotient caps at one: compare against 2^15*norm up front
      qbig <= 1'b0;
    end else if (cmd.div_step) begin
      if (dv_i == 4'd14 && ((pis_pkg::DotW+15)'(drem) >=
          ((pis_pkg::DotW+15)'(root) << 15))) begin
        qbig <= 1'b1;
      end
      if (!dsub[pis_pkg::DotW]) begin
        drem <= dsub[pis_pkg::DotW-1:0];
        quo  <= quo | (pis_pkg::QW'(1) << dv_i);
      end
      dv_i <= dv_i - 1'b1;
    end
    if (cmd.finish) begin
      score.inlier_flag  <= inl;
      score.match_cosine <= cosv;
      score.inlier_total <= (inl && cnt < pis_pkg::CntW'(CountCap)) ? cnt + 1'b1 : cnt;
      score.cost_total   <= csum[pis_pkg::CostW] ? '1 : csum[pis_pkg::CostW-1:0];
      score.run_end      <= m.last_match;
    end
  end

endmodule

FILE: sv/pis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pis_ctrl: sequencer for one match
// Load, three transform rows, sums, 35 root steps, 15 divide steps (skipped
// for a zero-length point), finish. Finish waits while the previous score
// word is still held at the output.
module pis_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pis_pkg::dp_stat_t stat,
  output pis_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_SUMS, S_SQRT, S_DIV, S_FIN
  } state_t;

  state_t     state;
  logic [5:0] step;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = in_valid && in_ready;
    cmd.row       = step[1:0];
    cmd.row_en    = (state == S_ROW);
    cmd.sums_en   = (state == S_SUMS);
    cmd.sqrt_init = (state == S_SUMS);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.div_init  = (state == S_SQRT) && (step == 6'd0);
    cmd.div_step  = (state == S_DIV);
    cmd.finish    = (state == S_FIN) && (!out_valid || out_ready);
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd.load) begin state <= S_ROW; step <= '0; end
        S_ROW: begin
          if (step == 6'd2) begin state <= S_SUMS; end
          step <= step + 1'b1;
        end
        S_SUMS: begin state <= S_SQRT; step <= 6'd34; end
        S_SQRT: begin
          if (step == 6'd0) begin
            state <= stat.zero_len ? S_FIN : S_DIV;
            step  <= 6'd14;
          end else step <= step - 1'b1;
        end
        S_DIV: begin
          if (step == 6'd0) state <= S_FIN;
          else step <= step - 1'b1;
        end
        S_FIN: if (cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
